// ===== rtl/lspv_pkg.sv =====
`timescale 1ns / 1ps

package lspv_pkg;

   localparam int MEM_DEPTH_DEF = 4096;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;
   localparam int CFG_POS_W  = 13;

   // integer part of the play position, and signed index math
   localparam int PI_W   = 16;
   localparam int IDX_W  = 17;
   localparam int DV_W   = 14;
   localparam int KW     = 21;
   localparam int HW     = 40;
   localparam int PROD_W = HW + 17;

   localparam int CLIP_MIN = -32768;
   localparam int CLIP_MAX = 32767;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SEEK  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] IM_NONE    = 2'd0;
   localparam logic [1:0] IM_LINEAR  = 2'd1;
   localparam logic [1:0] IM_CUBIC   = 2'd2;
   localparam logic [1:0] IM_HERMITE = 2'd3;

   localparam logic [1:0] LM_NONE = 2'd0;
   localparam logic [1:0] LM_FWD  = 2'd1;
   localparam logic [1:0] LM_PING = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_INTERP_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_MODE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_START  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_END    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_LEN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_INC    = 3'd5;

   localparam logic [1:0] FIX_NONE    = 2'd0;
   localparam logic [1:0] FIX_WRAP    = 2'd1;
   localparam logic [1:0] FIX_PP_BACK = 2'd2;
   localparam logic [1:0] FIX_PP_FWD  = 2'd3;

   typedef struct packed {
      logic [1:0]         operation;
      logic [11:0]        address;
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
      logic               start_reverse;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               ended;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_payload_type;

endpackage

// ===== rtl/lspv_ifs.sv =====
`timescale 1ns / 1ps

interface lspv_req_if;
   import lspv_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lspv_rsp_if;
   import lspv_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lspv_csr_if;
   import lspv_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/lspv_ram.sv =====
`timescale 1ns / 1ps

module lspv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/looped_sample_playback_voice_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req_chan  in   valid/ready            operation, address, left_in, right_in, start_reverse
// rsp_chan  out  valid/ready            left_out, right_out, ended (one per tick)
// csr_chan  in   valid/ready, always 1  index, data
//
// write and seek leave the unit idle; a tick's length depends per channel on the mode, none,
// linear, or cubic and hermite, set by the shared 40x9 multiplier taking two passes per
// horner step; a wrap or reflection after the step, or one before the read, runs through
// the one-bit-per-cycle remainder unit
// reset is synchronous, active high; sample memory is not cleared
// a pending result waits in the output register; req_ready is low while a tick runs

module looped_sample_playback_voice_unit import lspv_pkg::*; #(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   lspv_req_if.sink   req_chan,
   lspv_rsp_if.source rsp_chan,
   lspv_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int PW = PI_W + FRAC_BITS;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_APPLY = 4'd3;
   localparam logic [3:0] S_READ  = 4'd4;
   localparam logic [3:0] S_INIT  = 4'd5;
   localparam logic [3:0] S_MLO   = 4'd6;
   localparam logic [3:0] S_MHI   = 4'd7;
   localparam logic [3:0] S_ACC   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_STEP  = 4'd10;
   localparam logic [3:0] S_POST  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0] state_ff, state_in;

   logic [1:0]            interp_mode_ff;
   logic [1:0]            loop_mode_ff;
   logic [CFG_POS_W-1:0]  loop_start_ff;
   logic [CFG_POS_W-1:0]  loop_end_ff;
   logic [CFG_POS_W-1:0]  sample_length_ff;
   logic [CSR_DATA_W-1:0] step_increment_ff;

   logic signed [PW-1:0] pos_ff, pos_in;
   logic                 back_ff, back_in;
   logic                 fixed_ff, fixed_in;
   logic                 post_ff, post_in;
   logic [1:0]           fix_kind_ff, fix_kind_in;
   logic [DV_W-1:0]      divisor_ff, divisor_in;
   logic [DV_W-1:0]      dividend_ff, dividend_in;
   logic [DV_W:0]        rem_ff, rem_in;
   logic [3:0]           div_cnt_ff, div_cnt_in;
   logic [2:0]           rd_cnt_ff, rd_cnt_in;
   logic                 rd_ok_ff;
   logic signed [15:0]   xl_ff [4];
   logic signed [15:0]   xr_ff [4];
   logic                 ch_ff, ch_in;
   logic [1:0]           steps_ff, steps_in;
   logic signed [HW-1:0] h_ff, h_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [15:0]   res_l_ff, res_l_in;
   logic signed [15:0]   res_r_ff, res_r_in;
   logic                 res_end_ff, res_end_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 req_acc, csr_acc, out_free;
   logic signed [PI_W-1:0]  pos_int_c;
   logic [FRAC_BITS-1:0]    pos_frac_c;
   logic [15:0]             u_c;
   logic signed [PW-1:0]    inc_c;
   logic [CFG_POS_W-1:0]    len_c, ls_c, le_c;
   logic signed [IDX_W-1:0] t_s, ls_s, le_s, len_s, loop_len, per_s, r_s, d_s;
   logic signed [IDX_W-1:0] new_int, rd_idx_c;
   logic                    new_back, readable_c, fix_ok_c, rd_ok_c;
   logic [1:0]              fix_kind_c;
   logic [DV_W-1:0]         dividend_c, divisor_c;
   logic [DV_W:0]           trial_c;
   logic [31:0]             mem_rdata;
   logic                    mem_we;

   logic signed [KW-1:0]    x0, x1, x2, x3, k3, k2, k1, diff_c, coef_c;
   logic signed [8:0]       mul_b_c;
   logic signed [HW+8:0]    mul_p_c;
   logic signed [PROD_W-1:0] sh_c, q_c, x1s_c, fin_sh_c, rq_c;
   logic                    corr_c, fin_corr_c, herm_c;
   logic signed [15:0]      clip_c;

   assign req_acc  = req_chan.valid && req_chan.ready;
   assign csr_acc  = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign pos_int_c  = pos_ff[PW-1:FRAC_BITS];
   assign pos_frac_c = pos_ff[FRAC_BITS-1:0];

   generate
      if (FRAC_BITS >= 16) begin : g_wide_frac
         assign u_c   = 16'(pos_frac_c >> (FRAC_BITS - 16));
         assign inc_c = PW'(step_increment_ff) << (FRAC_BITS - 16);
      end else begin : g_narrow_frac
         assign u_c   = 16'(pos_frac_c) << (16 - FRAC_BITS);
         assign inc_c = PW'(step_increment_ff >> (16 - FRAC_BITS));
      end
   endgenerate

   // loop bounds
   always_comb begin
      if ({4'b0, sample_length_ff} < 17'(MEM_DEPTH)) begin
         len_c = sample_length_ff;
      end else begin
         len_c = CFG_POS_W'(MEM_DEPTH);
      end
      if (loop_mode_ff == LM_FWD || loop_mode_ff == LM_PING) begin
         ls_c = (loop_start_ff < len_c) ? loop_start_ff : len_c;
         le_c = (loop_end_ff < len_c) ? loop_end_ff : len_c;
      end else begin
         ls_c = '0;
         le_c = len_c;
      end
   end

   assign t_s      = IDX_W'(pos_int_c);
   assign ls_s     = signed'(IDX_W'(ls_c));
   assign le_s     = signed'(IDX_W'(le_c));
   assign len_s    = signed'(IDX_W'(len_c));
   assign loop_len = le_s - ls_s;
   assign per_s    = (loop_len <<< 1) - 1;
   assign readable_c = back_ff ? (t_s >= ls_s) : (t_s < le_s);

   // wrap / reflect decision
   always_comb begin
      fix_kind_c = FIX_NONE;
      dividend_c = DV_W'(t_s - le_s);
      divisor_c  = DV_W'(per_s);
      if (loop_mode_ff == LM_FWD && t_s >= le_s) begin
         fix_kind_c = FIX_WRAP;
         divisor_c  = DV_W'(loop_len);
      end else if (loop_mode_ff == LM_PING && back_ff && t_s < ls_s) begin
         fix_kind_c = FIX_PP_BACK;
         dividend_c = DV_W'(ls_s - t_s - 1);
      end else if (loop_mode_ff == LM_PING && !back_ff && t_s > 0 && t_s >= le_s) begin
         fix_kind_c = FIX_PP_FWD;
      end
      fix_ok_c = (fix_kind_c != FIX_NONE) && (loop_len > 0);
   end

   assign trial_c = {rem_ff[DV_W-1:0], dividend_ff[DV_W-1]};
   assign r_s     = signed'(IDX_W'(rem_ff));
   assign d_s     = r_s + 1;

   always_comb begin
      new_int  = ls_s + r_s;
      new_back = back_ff;
      case (fix_kind_ff)
         FIX_PP_BACK: begin
            if (d_s <= loop_len - 1) begin
               new_int  = ls_s + d_s;
               new_back = 1'b0;
            end else begin
               new_int  = le_s - 1 - (d_s - loop_len);
               new_back = 1'b1;
            end
         end
         FIX_PP_FWD: begin
            if (r_s <= loop_len - 1) begin
               new_int  = le_s - 1 - r_s;
               new_back = 1'b1;
            end else begin
               new_int  = le_s + r_s - per_s;
               new_back = 1'b0;
            end
         end
         default: begin
            new_int  = ls_s + r_s;
            new_back = back_ff;
         end
      endcase
   end

   // frame fetch
   assign rd_idx_c = t_s - 1 + signed'(IDX_W'(rd_cnt_ff));
   assign rd_ok_c  = (rd_idx_c >= 0) && (rd_idx_c < len_s);
   assign mem_we   = req_acc && (req_chan.payload.operation == OP_WRITE)
                     && ({5'b0, req_chan.payload.address} < 17'(MEM_DEPTH));

   lspv_ram #(
      .WIDTH (32),
      .DEPTH (MEM_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(req_chan.payload.address)),
      .wr_data ({req_chan.payload.right_in, req_chan.payload.left_in}),
      .rd_addr (rd_idx_c[AW-1:0]),
      .rd_data (mem_rdata)
   );

   // interpolation coefficients of the current channel
   always_comb begin
      x0 = KW'(ch_ff ? xr_ff[0] : xl_ff[0]);
      x1 = KW'(ch_ff ? xr_ff[1] : xl_ff[1]);
      x2 = KW'(ch_ff ? xr_ff[2] : xl_ff[2]);
      x3 = KW'(ch_ff ? xr_ff[3] : xl_ff[3]);
      herm_c = (interp_mode_ff == IM_HERMITE);
      diff_c = x2 - x1;
      if (herm_c) begin
         k1 = x2 - x0;
         k2 = (x0 <<< 1) - 5 * x1 + (x2 <<< 2) - x3;
         k3 = x3 - x0 + 3 * (x1 - x2);
      end else begin
         k3 = x3 - x2 - x0 + x1;
         k2 = x0 - x1 - k3;
         k1 = x2 - x0;
      end
      coef_c = (steps_ff == 2'd3) ? k2 : k1;
   end

   // shared multiplier, one byte of u per pass
   assign mul_b_c = (state_ff == S_MHI) ? {1'b0, u_c[15:8]} : {1'b0, u_c[7:0]};
   assign mul_p_c = h_ff * mul_b_c;

   assign sh_c   = acc_ff >>> 16;
   assign corr_c = acc_ff[PROD_W-1] && (acc_ff[15:0] != '0);
   assign q_c    = sh_c + {{(PROD_W-1){1'b0}}, corr_c};
   assign x1s_c  = PROD_W'(x1) <<< 16;

   assign fin_sh_c   = herm_c ? (acc_ff >>> 17) : (acc_ff >>> 16);
   assign fin_corr_c = acc_ff[PROD_W-1]
                       && (herm_c ? (acc_ff[16:0] != '0) : (acc_ff[15:0] != '0));
   assign rq_c       = fin_sh_c + {{(PROD_W-1){1'b0}}, fin_corr_c};

   always_comb begin
      if (rq_c > PROD_W'(CLIP_MAX)) begin
         clip_c = 16'(CLIP_MAX);
      end else if (rq_c < PROD_W'(CLIP_MIN)) begin
         clip_c = 16'(CLIP_MIN);
      end else begin
         clip_c = 16'(rq_c);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      back_in      = back_ff;
      fixed_in     = fixed_ff;
      post_in      = post_ff;
      fix_kind_in  = fix_kind_ff;
      divisor_in   = divisor_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      rd_cnt_in    = rd_cnt_ff;
      ch_in        = ch_ff;
      steps_in     = steps_ff;
      h_in         = h_ff;
      acc_in       = acc_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      res_end_in   = res_end_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_chan.payload.operation)
                  OP_SEEK: begin
                     pos_in  = PW'(req_chan.payload.address) << FRAC_BITS;
                     back_in = req_chan.payload.start_reverse;
                  end
                  OP_TICK: begin
                     fixed_in   = 1'b0;
                     res_end_in = 1'b0;
                     state_in   = S_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            if (readable_c) begin
               rd_cnt_in = '0;
               state_in  = S_READ;
            end else if (!fixed_ff && fix_ok_c) begin
               fix_kind_in = fix_kind_c;
               dividend_in = dividend_c;
               divisor_in  = divisor_c;
               rem_in      = '0;
               div_cnt_in  = '0;
               post_in     = 1'b0;
               state_in    = S_DIV;
            end else begin
               res_end_in = 1'b1;
               res_l_in   = '0;
               res_r_in   = '0;
               state_in   = S_OUT;
            end
         end
         S_DIV: begin
            rem_in      = (trial_c >= {1'b0, divisor_ff}) ? trial_c - {1'b0, divisor_ff}
                                                         : trial_c;
            dividend_in = dividend_ff << 1;
            div_cnt_in  = div_cnt_ff + 4'd1;
            if (div_cnt_ff == 4'(DV_W - 1)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            pos_in   = PW'(new_int) << FRAC_BITS;
            back_in  = new_back;
            fixed_in = 1'b1;
            state_in = post_ff ? S_OUT : S_CHECK;
         end
         S_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'd4) begin
               ch_in    = 1'b0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            case (interp_mode_ff)
               IM_NONE: begin
                  if (ch_ff) begin
                     res_r_in = 16'(x1);
                     state_in = S_STEP;
                  end else begin
                     res_l_in = 16'(x1);
                     ch_in    = 1'b1;
                  end
               end
               IM_LINEAR: begin
                  h_in     = HW'(diff_c);
                  steps_in = 2'd1;
                  state_in = S_MLO;
               end
               default: begin
                  h_in     = HW'(k3) <<< 16;
                  steps_in = 2'd3;
                  state_in = S_MLO;
               end
            endcase
         end
         S_MLO: begin
            acc_in   = PROD_W'(mul_p_c);
            state_in = S_MHI;
         end
         S_MHI: begin
            acc_in   = acc_ff + (PROD_W'(mul_p_c) <<< 8);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (steps_ff > 2'd1) begin
               h_in     = HW'(q_c) + (HW'(coef_c) <<< 16);
               steps_in = steps_ff - 2'd1;
               state_in = S_MLO;
            end else begin
               if (interp_mode_ff == IM_LINEAR) begin
                  acc_in = x1s_c + acc_ff;
               end else if (herm_c) begin
                  acc_in = (x1s_c <<< 1) + q_c;
               end else begin
                  acc_in = x1s_c + q_c;
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (ch_ff) begin
               res_r_in = clip_c;
               state_in = S_STEP;
            end else begin
               res_l_in = clip_c;
               ch_in    = 1'b1;
               state_in = S_INIT;
            end
         end
         S_STEP: begin
            pos_in   = back_ff ? pos_ff - inc_c : pos_ff + inc_c;
            state_in = S_POST;
         end
         S_POST: begin
            if (fix_ok_c) begin
               fix_kind_in = fix_kind_c;
               dividend_in = dividend_c;
               divisor_in  = divisor_c;
               rem_in      = '0;
               div_cnt_in  = '0;
               post_in     = 1'b1;
               state_in    = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.left_out  = res_l_ff;
               rsp_data_in.right_out = res_r_ff;
               rsp_data_in.ended     = res_end_ff;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         pos_ff            <= '0;
         back_ff           <= 1'b0;
         fixed_ff          <= 1'b0;
         interp_mode_ff    <= IM_NONE;
         loop_mode_ff      <= LM_NONE;
         loop_start_ff     <= '0;
         loop_end_ff       <= '0;
         sample_length_ff  <= '0;
         step_increment_ff <= CSR_DATA_W'(65536);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         back_ff      <= back_in;
         fixed_ff     <= fixed_in;
         if (csr_acc) begin
            unique case (csr_chan.payload.index)
               CSR_INTERP_MODE: interp_mode_ff    <= csr_chan.payload.data[1:0];
               CSR_LOOP_MODE:   loop_mode_ff      <= csr_chan.payload.data[1:0];
               CSR_LOOP_START:  loop_start_ff     <= csr_chan.payload.data[CFG_POS_W-1:0];
               CSR_LOOP_END:    loop_end_ff       <= csr_chan.payload.data[CFG_POS_W-1:0];
               CSR_SAMPLE_LEN:  sample_length_ff  <= csr_chan.payload.data[CFG_POS_W-1:0];
               CSR_STEP_INC:    step_increment_ff <= csr_chan.payload.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      post_ff     <= post_in;
      fix_kind_ff <= fix_kind_in;
      divisor_ff  <= divisor_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      rd_cnt_ff   <= rd_cnt_in;
      rd_ok_ff    <= rd_ok_c;
      ch_ff       <= ch_in;
      steps_ff    <= steps_in;
      h_ff        <= h_in;
      acc_ff      <= acc_in;
      res_l_ff    <= res_l_in;
      res_r_ff    <= res_r_in;
      res_end_ff  <= res_end_in;
      rsp_data_ff <= rsp_data_in;
      if (state_ff == S_READ && rd_cnt_ff != 3'd0) begin
         xl_ff[2'(rd_cnt_ff - 3'd1)] <= rd_ok_ff ? signed'(mem_rdata[15:0]) : 16'sd0;
         xr_ff[2'(rd_cnt_ff - 3'd1)] <= rd_ok_ff ? signed'(mem_rdata[31:16]) : 16'sd0;
      end
   end

   // ended results carry silence
   a_ended_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.ended) |->
         (rsp_data_ff.left_out == 16'sd0 && rsp_data_ff.right_out == 16'sd0))
      else $error("ended result with nonzero samples");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> (rem_ff < {1'b0, divisor_ff}))
      else $error("remainder not below divisor");

   a_fix_in_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |=> (t_s >= ls_s && t_s < le_s))
      else $error("wrapped position outside loop");

   a_fetch_readable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && rd_cnt_ff == 3'd0) |-> readable_c)
      else $error("frame fetch from unreadable position");

   a_quick_ops: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_chan.payload.operation != OP_TICK) |=> (state_ff == S_IDLE))
      else $error("write or seek left the idle state");

endmodule
